FILE: hw/rtl/stmn_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stmn_pkg : shared types and constants of the trimmed-mean normaliser
// Widths of the fixed words, the divider operation codes and the
// command / status bundles passed between controller and datapath.
// ----------------------------------------------------------------------------
package stmn_pkg;

  // defaults for the top-level parameters
  localparam int BURST_LEN_DEF   = 5;
  localparam int SAMPLE_BITS_DEF = 10;

  // fixed word widths
  localparam int NUM_CH  = 4;
  localparam int CH_W    = 2;
  localparam int IN_W    = 10;
  localparam int LEVEL_W = 7;
  localparam int STEER_W = 8;

  // percent scale and the width that holds it
  localparam int PCT   = 100;
  localparam int PCT_W = 7;

  // step sequence: NUM_CH means, NUM_CH levels, then the steering term
  localparam int STEP_W     = 4;
  localparam int STEER_STEP = 2 * NUM_CH;

  typedef enum logic [1:0] {
    OP_MEAN,
    OP_LEVEL,
    OP_STEER
  } op_t;

  // controller to datapath
  typedef struct packed {
    logic            load;       // snapshot word taken this cycle
    logic            first;      // snapshot opens a new burst
    logic            div_start;  // launch a division
    logic            store;      // keep a mean, or the quotient of a finished division
    logic            out_load;   // move results into the output register
    op_t             op;
    logic [CH_W-1:0] ch;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

FILE: hw/rtl/stmn_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stmn_div : iterative restoring divider
// One quotient bit per cycle. A zero divisor
// gives a zero quotient. done pulses for one cycle with the quotient valid.
// ----------------------------------------------------------------------------
module stmn_div #(
  parameter int NUM_BITS = 17,
  parameter int DEN_BITS = 10
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [NUM_BITS-1:0] num,
  input  wire logic [DEN_BITS-1:0] den,
  output logic                     done,
  output logic [NUM_BITS-1:0]      quo
);

  localparam int CNT_W = $clog2(NUM_BITS + 1);

  logic [NUM_BITS-1:0] q;
  logic [DEN_BITS-1:0] rem;
  logic [DEN_BITS-1:0] den_r;
  logic                zero;
  logic [CNT_W-1:0]    cnt;
  logic                busy;
  logic [DEN_BITS:0]   rem_sh;
  logic                fits;

  // trial subtract of the shifted remainder
  assign rem_sh = {rem, q[NUM_BITS-1]};
  assign fits   = rem_sh >= {1'b0, den_r};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      q     <= num;
      rem   <= '0;
      den_r <= den;
      zero  <= (den == '0);
    end else if (busy) begin
      q <= {q[NUM_BITS-2:0], fits};
      if (fits) begin
        rem <= DEN_BITS'(rem_sh - {1'b0, den_r});
      end else begin
        rem <= DEN_BITS'(rem_sh);
      end
    end
  end

  assign quo = zero ? '0 : q;

endmodule
`default_nettype wire

FILE: hw/rtl/stmn_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stmn_datapath : burst accumulators, running extremes, divider and results
// Per channel a burst sum, minimum and maximum are gathered as words arrive;
// the middle sum is the sum less both extremes. The means come from a
// reciprocal multiply; one shared divider does the percent levels and the
// steering term in turn.
// ----------------------------------------------------------------------------
module stmn_datapath #(
  parameter int BURST_LEN   = stmn_pkg::BURST_LEN_DEF,
  parameter int SAMPLE_BITS = stmn_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst,
  input  wire stmn_pkg::cmd_t                              cmd,
  output stmn_pkg::status_t                                status,
  input  wire logic [stmn_pkg::NUM_CH-1:0][stmn_pkg::IN_W-1:0] samples,
  output logic [stmn_pkg::NUM_CH-1:0][stmn_pkg::LEVEL_W-1:0]  levels,
  output logic [stmn_pkg::STEER_W-1:0]                     steer_out,
  output logic                                             out_valid,
  input  wire logic                                        out_ready
);

  import stmn_pkg::*;

  localparam int SUM_W = SAMPLE_BITS + $clog2(BURST_LEN);
  localparam int NUM_W = SAMPLE_BITS + PCT_W;
  localparam int DEN_W = SAMPLE_BITS;

  // mean by reciprocal: mid * ceil(2^RCP_SH / DIVR) >> RCP_SH, exact over SUM_W
  localparam int DIVR   = BURST_LEN - 2;
  localparam int RCP_SH = SUM_W + 4;
  localparam int RCP    = ((1 << RCP_SH) + DIVR - 1) / DIVR;
  localparam int PROD_W = SUM_W + RCP_SH + 1;

  logic [SAMPLE_BITS-1:0] samp  [NUM_CH];
  logic [SUM_W-1:0]       bsum  [NUM_CH];
  logic [SAMPLE_BITS-1:0] bmin  [NUM_CH];
  logic [SAMPLE_BITS-1:0] bmax  [NUM_CH];
  logic [SAMPLE_BITS-1:0] gmin  [NUM_CH];
  logic [SAMPLE_BITS-1:0] gmax  [NUM_CH];
  logic [SAMPLE_BITS-1:0] mean  [NUM_CH];
  logic [LEVEL_W-1:0]     level [NUM_CH];
  logic [STEER_W-1:0]     steer;

  logic [SUM_W-1:0]       mid;
  logic [PROD_W-1:0]      mean_prod;
  logic [SAMPLE_BITS-1:0] mean_calc;
  logic [SAMPLE_BITS-1:0] above;
  logic [SAMPLE_BITS-1:0] span;
  logic                   neg;
  logic [LEVEL_W-1:0]     mag;
  logic [LEVEL_W:0]       lsum;
  logic [NUM_W-1:0]       div_num;
  logic [DEN_W-1:0]       div_den;
  logic                   div_done;
  logic [NUM_W-1:0]       quo;
  logic [STEER_W-1:0]     quo_e;

  // input words trimmed or extended to the sample width
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      samp[c] = SAMPLE_BITS'(samples[c]);
    end
  end

  assign quo_e = STEER_W'(quo);

  // burst accumulators, means, levels, steering term
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int c = 0; c < NUM_CH; c++) begin
        if (cmd.first) begin
          bsum[c] <= SUM_W'(samp[c]);
          bmin[c] <= samp[c];
          bmax[c] <= samp[c];
        end else begin
          bsum[c] <= bsum[c] + SUM_W'(samp[c]);
          if (samp[c] < bmin[c]) bmin[c] <= samp[c];
          if (samp[c] > bmax[c]) bmax[c] <= samp[c];
        end
      end
    end
    if (cmd.store) begin
      case (cmd.op)
        OP_MEAN:  mean[cmd.ch]  <= mean_calc;
        OP_LEVEL: level[cmd.ch] <= LEVEL_W'(quo);
        OP_STEER: steer         <= neg ? (~quo_e + 1'b1) : quo_e;
        default: ;
      endcase
    end
  end

  // running extremes over raw samples and means
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CH; c++) begin
        gmin[c] <= '1;
        gmax[c] <= '0;
      end
    end else begin
      if (cmd.load) begin
        for (int c = 0; c < NUM_CH; c++) begin
          if (samp[c] < gmin[c]) gmin[c] <= samp[c];
          if (samp[c] > gmax[c]) gmax[c] <= samp[c];
        end
      end
      if (cmd.store && cmd.op == OP_MEAN) begin
        if (mean_calc < gmin[cmd.ch]) gmin[cmd.ch] <= mean_calc;
        if (mean_calc > gmax[cmd.ch]) gmax[cmd.ch] <= mean_calc;
      end
    end
  end

  // trimmed mean and divider operands
  always_comb begin
    mid       = bsum[cmd.ch] - SUM_W'(bmin[cmd.ch]) - SUM_W'(bmax[cmd.ch]);
    mean_prod = PROD_W'(mid) * PROD_W'(RCP);
    mean_calc = SAMPLE_BITS'(mean_prod >> RCP_SH);
    above     = mean[cmd.ch] - gmin[cmd.ch];
    span      = gmax[cmd.ch] - gmin[cmd.ch];
    neg       = level[1] < level[2];
    mag       = neg ? (level[2] - level[1]) : (level[1] - level[2]);
    lsum      = {1'b0, level[1]} + {1'b0, level[2]};
    case (cmd.op)
      OP_LEVEL: begin
        div_num = NUM_W'(above) * NUM_W'(PCT);
        div_den = span;
      end
      OP_STEER: begin
        div_num = NUM_W'(mag) * NUM_W'(PCT);
        div_den = DEN_W'(lsum);
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  stmn_div #(
    .NUM_BITS (NUM_W),
    .DEN_BITS (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (quo)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      for (int c = 0; c < NUM_CH; c++) begin
        levels[c] <= level[c];
      end
      steer_out <= steer;
    end
  end

  assign status.div_done = div_done;
  assign status.out_free = !out_valid || out_ready;

endmodule
`default_nettype wire

FILE: hw/rtl/stmn_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stmn_ctrl : burst sequencer
// Counts snapshot words into a burst, then steps the datapath through the
// four means, the four levels and the steering term before handing the
// result to the output register.
// ----------------------------------------------------------------------------
module stmn_ctrl #(
  parameter int BURST_LEN = stmn_pkg::BURST_LEN_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output stmn_pkg::cmd_t         cmd,
  input  wire stmn_pkg::status_t status
);

  import stmn_pkg::*;

  localparam int CNT_W = $clog2(BURST_LEN);

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_WAIT,
    S_OUT
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  count;
  logic [STEP_W-1:0] step;
  logic              accept;
  logic              mean_step;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign mean_step = (step < STEP_W'(NUM_CH));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      step  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (count == CNT_W'(BURST_LEN - 1)) begin
              count <= '0;
              step  <= '0;
              state <= S_START;
            end else begin
              count <= count + 1'b1;
            end
          end
        end
        S_START: begin
          // a mean is stored straight from S_START; the rest go through the divider
          if (mean_step) begin
            step <= step + 1'b1;
          end else begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (status.div_done) begin
            if (step == STEP_W'(STEER_STEP)) begin
              state <= S_OUT;
            end else begin
              step  <= step + 1'b1;
              state <= S_START;
            end
          end
        end
        S_OUT: begin
          if (status.out_free) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // commands
  always_comb begin
    cmd.load      = accept;
    cmd.first     = (count == '0);
    cmd.div_start = (state == S_START) && !mean_step;
    cmd.store     = ((state == S_START) && mean_step) ||
                    ((state == S_WAIT) && status.div_done);
    cmd.out_load  = (state == S_OUT) && status.out_free;
    cmd.ch        = step[CH_W-1:0];
    if (mean_step) begin
      cmd.op = OP_MEAN;
    end else if (step < STEP_W'(STEER_STEP)) begin
      cmd.op = OP_LEVEL;
    end else begin
      cmd.op = OP_STEER;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/sensor_trimmed_mean_normalizer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sensor_trimmed_mean_normalizer_top : four-channel trimmed-mean normaliser
// Gathers bursts of snapshot words and emits one percent-level result word
// per burst.
// ----------------------------------------------------------------------------
// Each input word carries one sample per channel and is taken when in_valid
// and in_ready are both high. The last word of a burst of BURST_LEN starts
// the computation: the four trimmed means are stored one after another
// through a reciprocal multiply, then one shared iterative divider, a
// quotient bit per cycle, works out four percent levels and the steering
// term in turn, and the result is loaded into the output register as soon
// as the previous result word is taken. No input word is taken meanwhile.
// The result then sits in the output register while the next burst is
// collected. Levels are (mean - min) * 100 / (max - min) against running
// per-channel extremes; a flat channel reads 0, and the steering error is 0
// when channels 1 and 2 both read 0.
// ----------------------------------------------------------------------------
module sensor_trimmed_mean_normalizer_top #(
  parameter int BURST_LEN   = stmn_pkg::BURST_LEN_DEF,
  parameter int SAMPLE_BITS = stmn_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [stmn_pkg::IN_W-1:0]          sample_ch0,
  input  wire logic [stmn_pkg::IN_W-1:0]          sample_ch1,
  input  wire logic [stmn_pkg::IN_W-1:0]          sample_ch2,
  input  wire logic [stmn_pkg::IN_W-1:0]          sample_ch3,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [stmn_pkg::LEVEL_W-1:0]            level_ch0,
  output logic [stmn_pkg::LEVEL_W-1:0]            level_ch1,
  output logic [stmn_pkg::LEVEL_W-1:0]            level_ch2,
  output logic [stmn_pkg::LEVEL_W-1:0]            level_ch3,
  output logic signed [stmn_pkg::STEER_W-1:0]     steer_error
);

  import stmn_pkg::*;

  cmd_t                               cmd;
  status_t                            status;
  logic [NUM_CH-1:0][IN_W-1:0]        samples;
  logic [NUM_CH-1:0][LEVEL_W-1:0]     levels;
  logic [STEER_W-1:0]                 steer_out;

  assign samples = {sample_ch3, sample_ch2, sample_ch1, sample_ch0};

  stmn_ctrl #(
    .BURST_LEN (BURST_LEN)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .status   (status)
  );

  stmn_datapath #(
    .BURST_LEN   (BURST_LEN),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .samples   (samples),
    .levels    (levels),
    .steer_out (steer_out),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

  assign level_ch0   = levels[0];
  assign level_ch1   = levels[1];
  assign level_ch2   = levels[2];
  assign level_ch3   = levels[3];
  assign steer_error = steer_out;

endmodule
`default_nettype wire

FILE: dv/tb_sensor_trimmed_mean_normalizer_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sensor_trimmed_mean_normalizer_top : self-checking bench of the normaliser
// Feeds snapshot words through the input handshake with random gaps, folds
// every accepted word into a bench-side model of bursts, trimmed means and
// running channel extremes, and checks each result word against it field by
// field while the result side stalls at random.
// ----------------------------------------------------------------------------
module tb_sensor_trimmed_mean_normalizer_top;
  import stmn_pkg::*;

  localparam int BURST       = BURST_LEN_DEF;
  localparam int SAMPLE_MASK = (1 << SAMPLE_BITS_DEF) - 1;
  localparam int FULL_SCALE  = (1 << IN_W) - 1;
  localparam int RAND_BURSTS = 340;

  typedef logic [NUM_CH-1:0][IN_W-1:0] snapshot_t;

  typedef struct packed {
    logic [NUM_CH-1:0][LEVEL_W-1:0] level;
    logic signed [STEER_W-1:0]      steer;
  } burst_result_t;

  // how one channel behaves across a random burst
  typedef enum int {
    SHAPE_WIDE,
    SHAPE_NARROW,
    SHAPE_FLAT,
    SHAPE_RAIL,
    SHAPE_SPIKE
  } burst_shape_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [IN_W-1:0] sample_ch0 = '0;
  logic [IN_W-1:0] sample_ch1 = '0;
  logic [IN_W-1:0] sample_ch2 = '0;
  logic [IN_W-1:0] sample_ch3 = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [LEVEL_W-1:0] level_ch0;
  logic [LEVEL_W-1:0] level_ch1;
  logic [LEVEL_W-1:0] level_ch2;
  logic [LEVEL_W-1:0] level_ch3;
  logic signed [STEER_W-1:0] steer_error;

  sensor_trimmed_mean_normalizer_top uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .sample_ch0  (sample_ch0),
    .sample_ch1  (sample_ch1),
    .sample_ch2  (sample_ch2),
    .sample_ch3  (sample_ch3),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .level_ch0   (level_ch0),
    .level_ch1   (level_ch1),
    .level_ch2   (level_ch2),
    .level_ch3   (level_ch3),
    .steer_error (steer_error)
  );

  // stimulus and expectations
  snapshot_t     snapshot_q[$];
  burst_result_t levels_due_q[$];
  int            words_taken = 0;
  int            mismatches = 0;

  // bench copy of the burst store and running extremes
  int burst_store[NUM_CH][BURST];
  int burst_fill;
  int chan_lo[NUM_CH];
  int chan_hi[NUM_CH];

  // idle pacing of both sides
  int send_gap = 0;
  int send_calm = 0;
  int take_gap = 0;
  int take_calm = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
  end

  // gap length: mostly none or short, now and then long, with calm runs of none
  function automatic int next_gap(inout int calm);
    int roll;
    int gap;
    roll = $urandom_range(0, 99);
    gap = 0;
    if (calm > 0) begin
      calm = calm - 1;
    end else if (roll < 3) begin
      calm = $urandom_range(20, 80);
    end else if (roll >= 94) begin
      gap = $urandom_range(8, 40);
    end else if (roll >= 60) begin
      gap = $urandom_range(1, 3);
    end
    return gap;
  endfunction

  function automatic snapshot_t snap4(input int s0, input int s1, input int s2,
                                      input int s3);
    snapshot_t s;
    s[0] = s0[IN_W-1:0];
    s[1] = s1[IN_W-1:0];
    s[2] = s2[IN_W-1:0];
    s[3] = s3[IN_W-1:0];
    return s;
  endfunction

  // fold one accepted word into the model; a full burst yields a result word
  task automatic fold_snapshot(input snapshot_t snap);
    int            srt[BURST];
    int            key;
    int            j;
    int            acc;
    int            mean;
    int            pct[NUM_CH];
    int            l1;
    int            l2;
    int            err;
    burst_result_t res;
    for (int c = 0; c < NUM_CH; c++) burst_store[c][burst_fill] = snap[c] & SAMPLE_MASK;
    burst_fill = burst_fill + 1;
    if (burst_fill == BURST) begin
      burst_fill = 0;
      // raw samples widen the extremes first
      for (int c = 0; c < NUM_CH; c++) begin
        for (int k = 0; k < BURST; k++) begin
          if (burst_store[c][k] > chan_hi[c]) chan_hi[c] = burst_store[c][k];
          if (burst_store[c][k] < chan_lo[c]) chan_lo[c] = burst_store[c][k];
        end
      end
      // trimmed mean per channel, then its place between the extremes
      for (int c = 0; c < NUM_CH; c++) begin
        for (int k = 0; k < BURST; k++) srt[k] = burst_store[c][k];
        for (int k = 1; k < BURST; k++) begin
          key = srt[k];
          j = k - 1;
          while (j >= 0 && srt[j] > key) begin
            srt[j + 1] = srt[j];
            j = j - 1;
          end
          srt[j + 1] = key;
        end
        acc = 0;
        for (int k = 1; k < BURST - 1; k++) acc = acc + srt[k];
        mean = acc / (BURST - 2);
        if (mean < chan_lo[c]) chan_lo[c] = mean;
        if (mean > chan_hi[c]) chan_hi[c] = mean;
        if (chan_hi[c] > chan_lo[c] && mean >= chan_lo[c])
          pct[c] = ((mean - chan_lo[c]) * PCT) / (chan_hi[c] - chan_lo[c]);
        else
          pct[c] = 0;
        if (pct[c] > PCT) pct[c] = PCT;
        res.level[c] = pct[c][LEVEL_W-1:0];
      end
      // steering term, signed division truncates toward zero
      l1 = pct[1];
      l2 = pct[2];
      err = (l1 + l2 != 0) ? ((l1 - l2) * PCT) / (l1 + l2) : 0;
      res.steer = err[STEER_W-1:0];
      levels_due_q.push_back(res);
    end
  endtask

  // one well-formed burst, each channel with a shape of its own
  task automatic queue_random_burst();
    snapshot_t    burst_snaps[BURST];
    burst_shape_t shape;
    int           base;
    int           spread;
    int           spike_at;
    int           v;
    for (int c = 0; c < NUM_CH; c++) begin
      shape = burst_shape_t'($urandom_range(0, 4));
      base = $urandom_range(0, FULL_SCALE);
      spread = $urandom_range(0, 60);
      spike_at = $urandom_range(0, BURST - 1);
      for (int k = 0; k < BURST; k++) begin
        v = base + $urandom_range(0, 2 * spread) - spread;
        if (v < 0) v = 0;
        if (v > FULL_SCALE) v = FULL_SCALE;
        case (shape)
          SHAPE_WIDE:  v = $urandom_range(0, FULL_SCALE);
          SHAPE_FLAT:  v = base;
          SHAPE_RAIL:  v = $urandom_range(0, 1) ? FULL_SCALE : 0;
          SHAPE_SPIKE: if (k == spike_at) v = $urandom_range(0, FULL_SCALE);
          default: ;
        endcase
        burst_snaps[k][c] = v[IN_W-1:0];
      end
    end
    for (int k = 0; k < BURST; k++) snapshot_q.push_back(burst_snaps[k]);
  endtask

  // input driver: takes words from the pending queue, holds each until taken
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
      burst_fill = 0;
      for (int c = 0; c < NUM_CH; c++) begin
        chan_lo[c] = FULL_SCALE;
        chan_hi[c] = 0;
      end
    end else begin
      if (in_valid && in_ready) begin
        fold_snapshot({sample_ch3, sample_ch2, sample_ch1, sample_ch0});
        words_taken = words_taken + 1;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap = send_gap - 1;
          in_valid <= 1'b0;
        end else if (snapshot_q.size() != 0) begin
          snapshot_t nxt;
          nxt = snapshot_q.pop_front();
          sample_ch0 <= nxt[0];
          sample_ch1 <= nxt[1];
          sample_ch2 <= nxt[2];
          sample_ch3 <= nxt[3];
          in_valid <= 1'b1;
          send_gap = next_gap(send_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: checks each taken word against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      take_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        burst_result_t want;
        logic [NUM_CH-1:0][LEVEL_W-1:0] seen;
        seen = {level_ch3, level_ch2, level_ch1, level_ch0};
        if (levels_due_q.size() == 0) begin
          $error("unexpected result word: level_ch0 %0d, steer_error %0d",
                 level_ch0, steer_error);
          mismatches = mismatches + 1;
        end else begin
          want = levels_due_q.pop_front();
          for (int c = 0; c < NUM_CH; c++) begin
            if (seen[c] !== want.level[c]) begin
              $error("level_ch%0d: expected %0d, actual %0d", c, want.level[c], seen[c]);
              mismatches = mismatches + 1;
            end
          end
          if (steer_error !== want.steer) begin
            $error("steer_error: expected %0d, actual %0d", want.steer, steer_error);
            mismatches = mismatches + 1;
          end
        end
      end
      if (take_gap > 0) begin
        take_gap = take_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        take_gap = next_gap(take_calm);
      end
    end
  end

  // stimulus, then wait for the last result and a quiet tail
  initial begin
    int total;
    // flat channels at both rails, a full ramp, alternating rails
    snapshot_q.push_back(snap4(0,    0, 1023,    0));
    snapshot_q.push_back(snap4(0,  256, 1023, 1023));
    snapshot_q.push_back(snap4(0,  512, 1023,    0));
    snapshot_q.push_back(snap4(0,  768, 1023, 1023));
    snapshot_q.push_back(snap4(0, 1023, 1023,    0));
    // channels 1 and 2 both at the bottom: zero sum
    repeat (BURST) snapshot_q.push_back(snap4(1023, 0, 0, 1023));
    // full negative steer, alternating bit patterns, walking ones
    snapshot_q.push_back(snap4(10'h2AA, 0, 1023,  1));
    snapshot_q.push_back(snap4(10'h155, 0, 1023,  2));
    snapshot_q.push_back(snap4(10'h2AA, 0, 1023,  4));
    snapshot_q.push_back(snap4(10'h155, 0, 1023,  8));
    snapshot_q.push_back(snap4(10'h2AA, 0, 1023, 16));
    // outliers at both ends trimmed away, fractional positive steer
    snapshot_q.push_back(snap4(1023, 700, 300,  32));
    snapshot_q.push_back(snap4(   0, 700, 300,  64));
    snapshot_q.push_back(snap4( 500, 700, 300, 128));
    snapshot_q.push_back(snap4( 501, 700, 300, 256));
    snapshot_q.push_back(snap4( 502, 700, 300, 512));
    // fractional negative steer, uneven order
    snapshot_q.push_back(snap4(1023, 300, 700, 1022));
    snapshot_q.push_back(snap4(   0, 301, 699,  513));
    snapshot_q.push_back(snap4( 999, 299, 701,    3));
    snapshot_q.push_back(snap4(   1, 300, 700,  777));
    snapshot_q.push_back(snap4( 511, 302, 698,  128));
    repeat (RAND_BURSTS) queue_random_burst();
    total = snapshot_q.size();

    do @(negedge clk); while (words_taken != total || levels_due_q.size() != 0);
    repeat (400) @(negedge clk);

    if (mismatches == 0 && levels_due_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
